// ===== hw/rtl/ura_pkg.sv =====
// shared constants and types of the unsigned radix-to-ascii converter
// no dependencies; used by ura_digits and unsigned_radix_to_ascii_top
`default_nettype none

package ura_pkg;

   // width of the value port and the number of value bits that are converted
   localparam int VALUE_PORT_W = 32;
   localparam int VALUE_WIDTH  = 32;
   localparam int DATA_W       = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;

   // digit counts per radix, ceil(w * log10(2)) for decimal
   localparam int DEC_DIGITS = (DATA_W * 30103 + 99999) / 100000;
   localparam int OCT_DIGITS = (DATA_W + 2) / 3;
   localparam int HEX_DIGITS = (DATA_W + 3) / 4;
   localparam int NDIG_A     = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
   localparam int NDIG       = (NDIG_A > HEX_DIGITS) ? NDIG_A : HEX_DIGITS;
   localparam int DIG_BITS   = NDIG * 4;

   localparam int CNT_W = $clog2(DATA_W + 1);
   localparam int REM_W = $clog2(NDIG + 1);

   // ascii codes
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_LOWER_X = 8'h78;
   localparam logic [7:0] ASCII_UPPER_X = 8'h58;

   // conversion selector
   typedef enum logic [1:0] {
      CMD_DEC  = 2'd0,
      CMD_OCT  = 2'd1,
      CMD_HEXL = 2'd2,
      CMD_HEXU = 2'd3
   } ura_cmd_type;

   // operations on the digit shift line
   typedef enum logic [1:0] {
      DIG_HOLD   = 2'd0,
      DIG_LOAD   = 2'd1,
      DIG_DABBLE = 2'd2,
      DIG_SHIFT  = 2'd3
   } ura_dig_op_type;

   typedef struct packed {
      ura_dig_op_type op;
      ura_cmd_type    cmd;
   } ura_dig_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ura_digits.sv =====
// digit shift line: loads octal/hex digits directly, builds bcd digits with a
// bit-serial shift-add-3 pass, and shifts digits out most significant first
// depends on ura_pkg
`default_nettype none

module ura_digits (
   input  wire logic                          clock,
   input  wire ura_pkg::ura_dig_ctl_type      ctl,
   input  wire logic [ura_pkg::DATA_W-1:0]    value,
   output logic      [3:0]                    top_digit
);

   logic [ura_pkg::DIG_BITS-1:0] dig_ff, dig_in;
   logic [ura_pkg::DATA_W-1:0]   val_ff, val_in;
   logic [ura_pkg::DIG_BITS-1:0] pad;
   logic [ura_pkg::DIG_BITS-1:0] load_dig;
   logic [ura_pkg::DIG_BITS-1:0] adj;

   assign pad = ura_pkg::DIG_BITS'(value);

   // digit split of the loaded value, octal or hex
   always_comb begin
      for (int i = 0; i < ura_pkg::NDIG; i++) begin
         if (ctl.cmd == ura_pkg::CMD_OCT) begin
            load_dig[4*i +: 4] = {1'b0, pad[3*i +: 3]};
         end else begin
            load_dig[4*i +: 4] = pad[4*i +: 4];
         end
      end
   end

   // add 3 to every bcd digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < ura_pkg::NDIG; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   // next state of the shift line
   always_comb begin
      dig_in = dig_ff;
      val_in = val_ff;
      unique case (ctl.op)
         ura_pkg::DIG_HOLD: begin
         end
         ura_pkg::DIG_LOAD: begin
            val_in = value;
            if (ctl.cmd == ura_pkg::CMD_DEC) begin
               dig_in = '0;
            end else begin
               dig_in = load_dig;
            end
         end
         ura_pkg::DIG_DABBLE: begin
            dig_in = {adj[ura_pkg::DIG_BITS-2:0], val_ff[ura_pkg::DATA_W-1]};
            val_in = {val_ff[ura_pkg::DATA_W-2:0], 1'b0};
         end
         ura_pkg::DIG_SHIFT: begin
            dig_in = {dig_ff[ura_pkg::DIG_BITS-5:0], 4'b0000};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
      val_ff <= val_in;
   end

   assign top_digit = dig_ff[ura_pkg::DIG_BITS-1 -: 4];

endmodule

`default_nettype wire

// ===== hw/rtl/unsigned_radix_to_ascii_top.sv =====
// unsigned radix-to-ascii converter, top level: control sequencer and output register
// depends on ura_pkg and ura_digits
//
// Usage: req_ carries one item (cmd, value, alternate_form) with valid/ready.
// rsp_ returns the item's ascii characters one per handshake, most significant
// digit first, no leading zeros, rsp_last set on the final character. A zero
// value gives a single '0'; alternate_form adds "0", "0x" or "0X" for nonzero
// octal and hex values. The block takes one item at a time: req_ready is high
// while the sequencer is idle, which includes the cycles in which the final
// character still waits in the output register.
// Sequence: decimal first runs a bit-serial shift-add-3 pass over every value
// bit, then the 11-digit shift line drops leading zeros one digit at a time and
// takes a decision step, then the prefix characters and the digits are emitted.
// A receiver stall freezes the sequencer on the character it is about to emit;
// nothing is lost.
// Reset (synchronous, active high) returns to idle with no result pending.
`default_nettype none

module unsigned_radix_to_ascii_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_value,
   input  wire logic        req_alternate_form,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_character,
   output logic             rsp_last
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CONV    = 6'b000010,
      S_SKIP    = 6'b000100,
      S_PREFIX0 = 6'b001000,
      S_PREFIXX = 6'b010000,
      S_DIGITS  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   ura_pkg::ura_cmd_type          cmd_ff, cmd_in;
   logic                          alt_ff, alt_in;
   logic                          nz_ff, nz_in;
   logic [ura_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ura_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_character_ff, rsp_character_in;
   logic                          rsp_last_ff, rsp_last_in;

   ura_pkg::ura_dig_ctl_type      dig_ctl;
   logic [ura_pkg::DATA_W-1:0]    value_masked;
   logic [3:0]                    top_digit;
   logic [7:0]                    letter;
   logic [7:0]                    digit_char;
   logic                          slot_free;

   assign value_masked = req_value[ura_pkg::DATA_W-1:0];
   assign slot_free    = ~rsp_valid_ff | rsp_ready;
   assign req_ready    = (state_ff == S_IDLE);

   // digit shift line
   ura_digits u_digits (
      .clock     (clock),
      .ctl       (dig_ctl),
      .value     (value_masked),
      .top_digit (top_digit)
   );

   // ascii code of the top digit
   assign letter = (cmd_ff == ura_pkg::CMD_HEXU) ? ura_pkg::ASCII_UPPER_A
                                                 : ura_pkg::ASCII_LOWER_A;
   always_comb begin
      if (top_digit < 4'd10) begin
         digit_char = ura_pkg::ASCII_ZERO + {4'b0000, top_digit};
      end else begin
         digit_char = letter + {4'b0000, top_digit} - 8'd10;
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      alt_in           = alt_ff;
      nz_in            = nz_ff;
      cnt_in           = cnt_ff;
      rem_in           = rem_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      dig_ctl.op       = ura_pkg::DIG_HOLD;
      dig_ctl.cmd      = cmd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in      = ura_pkg::ura_cmd_type'(req_cmd);
               alt_in      = req_alternate_form;
               nz_in       = (value_masked != '0);
               cnt_in      = ura_pkg::CNT_W'(ura_pkg::DATA_W);
               rem_in      = ura_pkg::REM_W'(ura_pkg::NDIG);
               dig_ctl.op  = ura_pkg::DIG_LOAD;
               dig_ctl.cmd = ura_pkg::ura_cmd_type'(req_cmd);
               if (ura_pkg::ura_cmd_type'(req_cmd) == ura_pkg::CMD_DEC) begin
                  state_in = S_CONV;
               end else begin
                  state_in = S_SKIP;
               end
            end
         end
         S_CONV: begin
            dig_ctl.op = ura_pkg::DIG_DABBLE;
            cnt_in     = cnt_ff - ura_pkg::CNT_W'(1);
            if (cnt_ff == ura_pkg::CNT_W'(1)) begin
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            // drop leading zero digits, keeping at least one
            priority if (rem_ff != ura_pkg::REM_W'(1) && top_digit == 4'd0) begin
               dig_ctl.op = ura_pkg::DIG_SHIFT;
               rem_in     = rem_ff - ura_pkg::REM_W'(1);
            end else if (alt_ff && nz_ff && cmd_ff != ura_pkg::CMD_DEC) begin
               state_in = S_PREFIX0;
            end else begin
               state_in = S_DIGITS;
            end
         end
         S_PREFIX0: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = ura_pkg::ASCII_ZERO;
               rsp_last_in      = 1'b0;
               state_in = (cmd_ff == ura_pkg::CMD_OCT) ? S_DIGITS : S_PREFIXX;
            end
         end
         S_PREFIXX: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = (cmd_ff == ura_pkg::CMD_HEXU) ? ura_pkg::ASCII_UPPER_X
                                                                : ura_pkg::ASCII_LOWER_X;
               rsp_last_in      = 1'b0;
               state_in         = S_DIGITS;
            end
         end
         S_DIGITS: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = digit_char;
               rsp_last_in      = (rem_ff == ura_pkg::REM_W'(1));
               dig_ctl.op       = ura_pkg::DIG_SHIFT;
               rem_in           = rem_ff - ura_pkg::REM_W'(1);
               if (rem_ff == ura_pkg::REM_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      alt_ff           <= alt_in;
      nz_ff            <= nz_in;
      cnt_ff           <= cnt_in;
      rem_ff           <= rem_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the conversion counter never wraps
   a_conv_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV) |-> (cnt_ff != '0))
      else $error("conversion counter reached zero inside conversion");

   // digit emission always has a digit left
   a_digits_left : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGITS) |-> (rem_ff != '0))
      else $error("digit emission with no digit left");

   // the final digit is marked last and returns the sequencer to idle
   a_last_digit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGITS && slot_free && rem_ff == ura_pkg::REM_W'(1))
      |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final digit not marked last");

   // prefix characters are never the end of a run
   a_prefix_not_last : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_PREFIX0 || state_ff == S_PREFIXX) && slot_free)
      |=> (rsp_valid_ff && !rsp_last_ff))
      else $error("prefix character marked last");
`endif

endmodule

`default_nettype wire
